/* hdl/bpg_pkg.sv */
// Shared types and constants for the beeper pattern generator.
// No dependencies; used by bpg_div, beeper_pattern_generator and the testbench.
package bpg_pkg;

  localparam int unsigned WIDTH_MS_W = 15;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned TICKS_W    = 16;

  // Command armed by a command item and applied by the next tick.
  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_START = 2'd2
  } cmd_t;

endpackage

/* hdl/bpg_div.sv */
// Converts a width in milliseconds into a period in ticks (truncating).
// Depends on bpg_pkg for field widths.
module bpg_div #(
  parameter int unsigned TICK_MS = 10
) (
  input  logic [bpg_pkg::WIDTH_MS_W-1:0] width_ms,
  output logic [bpg_pkg::TICKS_W-1:0]    period_ticks
);

  // Exact reciprocal for every numerator below 2**WIDTH_MS_W.
  localparam int unsigned SHIFT = bpg_pkg::WIDTH_MS_W + $clog2(TICK_MS);
  localparam longint unsigned MULT = ((64'd1 << SHIFT) + TICK_MS - 1) / TICK_MS;
  localparam int unsigned PROD_W = bpg_pkg::WIDTH_MS_W + 16;

  logic [15:0]       mult_c;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] quot;

  assign mult_c = MULT[15:0];
  assign prod   = PROD_W'(width_ms) * PROD_W'(mult_c);
  assign quot   = prod >> SHIFT;
  assign period_ticks = {1'b0, quot[bpg_pkg::WIDTH_MS_W-1:0]};

endmodule

/* hdl/beeper_pattern_generator.sv */
// Top level of the beeper pattern generator: handshake, pattern state, results.
// Depends on bpg_pkg and bpg_div.
// An item passes the input register, then the result register. Throughput: one item per
// cycle unless m_tready stalls; each item is one pass of counter logic and a small multiply.
// Reset (rst, synchronous): clears all pattern state and both valid flags.
module beeper_pattern_generator #(
  parameter int unsigned TICK_MS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata fields, lowest bit up: width_ms[14:0], beep_count[22:15], zero pad.
  input  logic [23:0] s_tdata,
  // s_tuser fields: func (0 = system tick, 1 = new beep command).
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata fields, lowest bit up: amp_enable, tone_on, active, zero pad.
  output logic [7:0]  m_tdata
);

  // Input register stage. It holds one item until the update pass runs.
  logic                            in_valid;
  logic                            in_func;
  logic [bpg_pkg::WIDTH_MS_W-1:0]  in_width;
  logic [bpg_pkg::COUNT_W-1:0]     in_count;

  // Pattern state.
  bpg_pkg::cmd_t                   pending_cmd, pending_cmd_next;
  logic                            running, running_next;
  logic                            phase, phase_next;
  logic [bpg_pkg::TICKS_W-1:0]     ticks_left, ticks_left_next;
  logic [bpg_pkg::TICKS_W-1:0]     period_ticks, period_ticks_next;
  logic [bpg_pkg::COUNT_W-1:0]     beeps_left, beeps_left_next;
  logic                            tone_level, tone_level_next;
  logic                            enable_level, enable_level_next;

  logic [bpg_pkg::TICKS_W-1:0]     cmd_period;
  logic                            out_load;
  logic                            fire;

  // The result register can take a new result when it is empty or being
  // drained this cycle; the input register then passes its item on and
  // takes a new one. When empty, it takes one even while a result waits.
  assign out_load = !m_tvalid || m_tready;
  assign fire     = in_valid && out_load;
  assign s_tready = !in_valid || out_load;

  bpg_div #(
    .TICK_MS (TICK_MS)
  ) u_div (
    .width_ms     (in_width),
    .period_ticks (cmd_period)
  );

  always_comb begin
    pending_cmd_next  = pending_cmd;
    running_next      = running;
    phase_next        = phase;
    ticks_left_next   = ticks_left;
    period_ticks_next = period_ticks;
    beeps_left_next   = beeps_left;
    tone_level_next   = tone_level;
    enable_level_next = enable_level;

    if (fire) begin
      if (in_func) begin
        // A command only records the request; the pattern values are
        // overwritten at once and a running pattern picks them up.
        if (in_width == '0 || in_count == '0) begin
          beeps_left_next   = '0;
          period_ticks_next = '0;
          pending_cmd_next  = bpg_pkg::CMD_STOP;
        end else begin
          beeps_left_next   = in_count;
          period_ticks_next = cmd_period;
          pending_cmd_next  = bpg_pkg::CMD_START;
        end
      end else begin
        // A tick first applies any armed command. The unused code is
        // treated as a start.
        unique case (pending_cmd)
          bpg_pkg::CMD_NONE: begin
          end
          bpg_pkg::CMD_STOP: begin
            enable_level_next = 1'b0;
            running_next      = 1'b0;
            ticks_left_next   = bpg_pkg::TICKS_W'(1);
          end
          default: begin
            enable_level_next = 1'b1;
            phase_next        = 1'b0;
            running_next      = 1'b1;
            ticks_left_next   = bpg_pkg::TICKS_W'(1);
          end
        endcase
        pending_cmd_next = bpg_pkg::CMD_NONE;

        // Then the pattern advances by one tick.
        if (!running_next) begin
          // Right after a stop, silence the tone once.
          if (ticks_left_next != '0) begin
            tone_level_next = 1'b0;
            ticks_left_next = '0;
          end
        end else if (period_ticks_next != '0) begin
          // Square wave: toggle every period, one beep per tone-on/tone-off pair.
          if (ticks_left_next > bpg_pkg::TICKS_W'(1)) begin
            ticks_left_next = ticks_left_next - bpg_pkg::TICKS_W'(1);
          end else if (beeps_left_next != '0) begin
            ticks_left_next = period_ticks_next;
            phase_next      = !phase_next;
            if (phase_next) begin
              tone_level_next = 1'b1;
            end else begin
              tone_level_next = 1'b0;
              beeps_left_next = beeps_left_next - bpg_pkg::COUNT_W'(1);
            end
          end else begin
            tone_level_next = 1'b0;
            running_next    = 1'b0;
            ticks_left_next = '0;
          end
        end else if (beeps_left_next != '0) begin
          // Width below one tick: a single beep lasting beep_count ticks.
          if (!phase_next) begin
            ticks_left_next = bpg_pkg::TICKS_W'(beeps_left_next);
            phase_next      = 1'b1;
            tone_level_next = 1'b1;
          end else if (ticks_left_next > bpg_pkg::TICKS_W'(1)) begin
            ticks_left_next = ticks_left_next - bpg_pkg::TICKS_W'(1);
          end else begin
            tone_level_next = 1'b0;
            running_next    = 1'b0;
            ticks_left_next = '0;
          end
        end else if (!phase_next) begin
          // Zero period and zero count while running: continuous tone.
          phase_next      = 1'b1;
          tone_level_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      m_tvalid     <= 1'b0;
      pending_cmd  <= bpg_pkg::CMD_NONE;
      running      <= 1'b0;
      phase        <= 1'b0;
      ticks_left   <= '0;
      period_ticks <= '0;
      beeps_left   <= '0;
      tone_level   <= 1'b0;
      enable_level <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (out_load) begin
        m_tvalid <= in_valid;
      end
      pending_cmd  <= pending_cmd_next;
      running      <= running_next;
      phase        <= phase_next;
      ticks_left   <= ticks_left_next;
      period_ticks <= period_ticks_next;
      beeps_left   <= beeps_left_next;
      tone_level   <= tone_level_next;
      enable_level <= enable_level_next;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_func  <= s_tuser;
      in_width <= s_tdata[14:0];
      in_count <= s_tdata[22:15];
    end
    if (fire) begin
      m_tdata <= {5'b0, running_next, tone_level_next, enable_level_next};
    end
  end

endmodule

/* hdl/bpg_checker.sv */
// Port-level assertions for beeper_pattern_generator, attached by bind.
// No package dependencies.
module bpg_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // A pending result is not withdrawn or changed while stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed or dropped while stalled");

  // A running pattern always has the driver enabled.
  a_active_enable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> m_tdata[0])
    else $error("active without amp_enable");

  // The tone only sounds while a pattern runs.
  a_tone_active: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> m_tdata[2])
    else $error("tone_on without active");

  // No result is offered right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind beeper_pattern_generator bpg_checker u_bpg_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* verif/beeper_pattern_generator_test.sv */
// Self-checking testbench for beeper_pattern_generator: directed and random ticks and
// beep commands, with random stalls on both stream ports and two long output hold-offs.
// Depends on bpg_pkg and the beeper_pattern_generator RTL; nothing else.
`timescale 1ns / 1ps

module beeper_pattern_generator_test;

  localparam int unsigned TICK_MS     = 10;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned RANDOM_ITEMS = 1750;

  // One input item as the sender sees it.
  typedef struct packed {
    logic                           func;
    logic [bpg_pkg::WIDTH_MS_W-1:0] width;
    logic [bpg_pkg::COUNT_W-1:0]    count;
  } beep_item_t;

  // The three driver levels returned for every item.
  typedef struct packed {
    logic amp;
    logic tone;
    logic act;
  } levels_t;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_CMD  = 1'b1;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;

  beeper_pattern_generator #(
    .TICK_MS(TICK_MS)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Items waiting to be offered, and levels waiting to come back.
  beep_item_t stim_q[$];
  levels_t    levels_q[$];

  int unsigned errors     = 0;
  int unsigned items_in   = 0;
  int unsigned results_ok = 0;
  int unsigned n_ticks    = 0;
  int unsigned n_cmds     = 0;
  int unsigned n_starts   = 0;
  int unsigned n_finished = 0;
  int unsigned cycles     = 0;

  // Predicted pattern state, tracked item by item in acceptance order.
  bpg_pkg::cmd_t               pend_cmd   = bpg_pkg::CMD_NONE;
  logic                        pat_run    = 1'b0;
  logic                        tone_phase = 1'b0;
  logic [bpg_pkg::TICKS_W-1:0] tick_cnt   = '0;
  logic [bpg_pkg::TICKS_W-1:0] period_cnt = '0;
  logic [bpg_pkg::COUNT_W-1:0] beeps_cnt  = '0;
  logic                        tone_lvl   = 1'b0;
  logic                        amp_lvl    = 1'b0;

  // Ends the pattern: tone off, nothing running, counter cleared, finish counted.
  task automatic end_pattern();
    tone_lvl = 1'b0;
    pat_run  = 1'b0;
    tick_cnt = '0;
    n_finished++;
  endtask

  // Updates the predicted state for one accepted item and returns the levels
  // the block should report for it.
  task automatic beep_predict(input beep_item_t it, output levels_t lv);
    if (it.func == FUNC_CMD) begin
      // A command only arms; its width and count land in the pattern state
      // at once, so a running pattern picks them up on its next tick.
      n_cmds++;
      if (it.width == '0 || it.count == '0) begin
        beeps_cnt  = '0;
        period_cnt = '0;
        pend_cmd   = bpg_pkg::CMD_STOP;
      end else begin
        beeps_cnt  = it.count;
        period_cnt = bpg_pkg::TICKS_W'(it.width / TICK_MS);
        pend_cmd   = bpg_pkg::CMD_START;
      end
    end else begin
      n_ticks++;
      // The tick first applies whatever was armed last.
      if (pend_cmd != bpg_pkg::CMD_NONE) begin
        if (pend_cmd != bpg_pkg::CMD_STOP) begin
          amp_lvl    = 1'b1;
          tone_phase = 1'b0;
          pat_run    = 1'b1;
          n_starts++;
        end else begin
          amp_lvl = 1'b0;
          pat_run = 1'b0;
        end
        tick_cnt = bpg_pkg::TICKS_W'(1);
        pend_cmd = bpg_pkg::CMD_NONE;
      end
      // Then it advances the pattern by one tick.
      if (!pat_run) begin
        if (tick_cnt != 0) begin
          tone_lvl = 1'b0;
          tick_cnt = '0;
        end
      end else if (period_cnt != 0) begin
        // Normal pattern: toggle every period, one beep per tone-on/tone-off pair.
        if (tick_cnt > 1) begin
          tick_cnt = tick_cnt - 1'b1;
        end else if (beeps_cnt != 0) begin
          tick_cnt   = period_cnt;
          tone_phase = ~tone_phase;
          if (tone_phase) begin
            tone_lvl = 1'b1;
          end else begin
            tone_lvl  = 1'b0;
            beeps_cnt = beeps_cnt - 1'b1;
          end
        end else begin
          end_pattern();
        end
      end else if (beeps_cnt != 0) begin
        // Width below one tick: a single beep that lasts count ticks.
        if (!tone_phase) begin
          tick_cnt   = bpg_pkg::TICKS_W'(beeps_cnt);
          tone_phase = 1'b1;
          tone_lvl   = 1'b1;
        end else if (tick_cnt > 1) begin
          tick_cnt = tick_cnt - 1'b1;
        end else begin
          end_pattern();
        end
      end else if (!tone_phase) begin
        // Zero period and zero count while running: the tone just stays on.
        tone_phase = 1'b1;
        tone_lvl   = 1'b1;
      end
    end
    lv.amp  = amp_lvl;
    lv.tone = tone_lvl;
    lv.act  = pat_run;
  endtask

  // Mostly no gap, sometimes a short one, now and then a long one. A calm
  // stretch gives no gaps at all.
  function automatic int unsigned gap_len(input logic calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_cmd(input int unsigned width, input int unsigned count);
    beep_item_t it;
    it.func  = FUNC_CMD;
    it.width = bpg_pkg::WIDTH_MS_W'(width);
    it.count = bpg_pkg::COUNT_W'(count);
    stim_q.push_back(it);
  endtask

  // Ticks carry random data in the other fields; the block must ignore it.
  task automatic push_ticks(input int unsigned n);
    beep_item_t it;
    repeat (n) begin
      it.func  = FUNC_TICK;
      it.width = bpg_pkg::WIDTH_MS_W'($urandom);
      it.count = bpg_pkg::COUNT_W'($urandom);
      stim_q.push_back(it);
    end
  endtask

  // Number of ticks a start needs to play out in full, plus a little slack.
  function automatic int unsigned pattern_ticks(input int unsigned width,
                                                input int unsigned count);
    int unsigned p;
    p = width / TICK_MS;
    if (width == 0 || count == 0) return 2;
    if (p == 0) return count + 2;
    return 2 * p * count + 3;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offers the queued items, holding each until it is taken.
  // ---------------------------------------------------------------------------
  logic        s_fire   = 1'b0;
  logic        src_calm = 1'b0;
  int unsigned src_wait = 0;

  always @(negedge clk) begin : drive_items
    beep_item_t nxt;
    if ($urandom_range(0, 63) == 0) src_calm <= ~src_calm;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_fire) begin
      if (src_wait != 0) begin
        s_tvalid <= 1'b0;
        src_wait <= src_wait - 1;
      end else if (stim_q.size() != 0) begin
        nxt = stim_q.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= nxt.func;
        s_tdata  <= {1'b0, nxt.count, nxt.width};
        src_wait <= gap_len(src_calm);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus two long hold-offs while the sender keeps
  // offering, so the block backs up and drops s_tready.
  // ---------------------------------------------------------------------------
  logic        sink_calm  = 1'b0;
  int unsigned sink_wait  = 0;
  int unsigned hold_left  = 0;
  int unsigned holds_done = 0;

  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) sink_calm <= ~sink_calm;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && items_in >= (holds_done + 1) * 600) begin
      m_tready   <= 1'b0;
      hold_left  <= $urandom_range(150, 300);
      holds_done <= holds_done + 1;
    end else if (sink_wait != 0) begin
      m_tready  <= 1'b0;
      sink_wait <= sink_wait - 1;
    end else begin
      m_tready  <= 1'b1;
      sink_wait <= gap_len(sink_calm);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on every accepted input item and checks every accepted
  // result against the oldest prediction. One process, so the queue order is
  // fixed even when an item and a result are taken together.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_levels
    beep_item_t it;
    levels_t    want;
    levels_t    got;
    s_fire <= s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      it.func  = s_tuser;
      it.width = s_tdata[14:0];
      it.count = s_tdata[22:15];
      beep_predict(it, want);
      levels_q.push_back(want);
      items_in++;
    end
    if (!rst && m_tvalid && m_tready) begin
      got.amp  = m_tdata[0];
      got.tone = m_tdata[1];
      got.act  = m_tdata[2];
      if (levels_q.size() == 0) begin
        $display("%0t: unexpected result, m_tdata %02h with nothing predicted",
                 $realtime, m_tdata);
        errors++;
      end else begin
        want = levels_q.pop_front();
        if (got.amp !== want.amp) begin
          $display("%0t: amp_enable expected %0b got %0b", $realtime, want.amp, got.amp);
          errors++;
        end
        if (got.tone !== want.tone) begin
          $display("%0t: tone_on expected %0b got %0b", $realtime, want.tone, got.tone);
          errors++;
        end
        if (got.act !== want.act) begin
          $display("%0t: active expected %0b got %0b", $realtime, want.act, got.act);
          errors++;
        end
        if (m_tdata[7:3] !== 5'b0) begin
          $display("%0t: m_tdata pad expected 00 got %02h", $realtime, m_tdata[7:3]);
          errors++;
        end
        results_ok++;
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycles, levels_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned r;
    int unsigned w;
    int unsigned n;
    int unsigned w2;
    int unsigned n2;
    int unsigned target;

    // Directed part. A tick straight after reset does nothing.
    push_ticks(1);
    // Widest width with the largest count: a start with a very long period.
    push_cmd(32767, 255);
    push_ticks(2);
    // Zero width with a nonzero count arms a stop.
    push_cmd(0, 255);
    push_ticks(1);
    // Width below one tick: one beep lasting count ticks.
    push_cmd(9, 3);
    push_ticks(5);
    // Two commands before a tick: the later start wins over the stop.
    push_cmd(0, 0);
    push_cmd(10, 1);
    push_ticks(4);
    // A stop arriving mid-pattern clears count and period before it applies.
    push_cmd(40, 3);
    push_ticks(2);
    push_cmd(20, 0);
    push_ticks(1);
    push_cmd(0, 1);
    push_ticks(1);

    // Random part: mostly complete patterns with random short widths and
    // counts, with interruptions, late stops and some raw noise mixed in.
    target = stim_q.size() + RANDOM_ITEMS;
    while (stim_q.size() < target) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        case ($urandom_range(0, 3))
          0:       w = $urandom_range(1, 9);
          1, 2:    w = $urandom_range(10, 49);
          default: w = $urandom_range(50, 99);
        endcase
        n = $urandom_range(1, 4);
        push_cmd(w, n);
        if ($urandom_range(0, 9) == 0) begin
          // Replaced before any tick: only the last command counts.
          w = $urandom_range(1, 49);
          n = $urandom_range(1, 3);
          push_cmd(w, n);
        end
        if ($urandom_range(0, 4) == 0) begin
          // Interrupt the pattern part way with a new start or a stop.
          push_ticks($urandom_range(1, pattern_ticks(w, n)));
          w2 = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 49) : 0;
          n2 = $urandom_range(0, 3);
          push_cmd(w2, n2);
          push_ticks(pattern_ticks(w2, n2) + $urandom_range(0, 2));
        end else begin
          push_ticks(pattern_ticks(w, n) + $urandom_range(0, 3));
        end
        if ($urandom_range(0, 2) == 0) begin
          // A late stop drops the amplifier enable.
          if ($urandom_range(0, 1) != 0) push_cmd(0, $urandom_range(0, 255));
          else push_cmd($urandom_range(0, 32767), 0);
          push_ticks($urandom_range(1, 2));
        end
      end else begin
        // Noise: full-range commands, zero fields, short bursts of ticks.
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1) != 0) begin
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 32767);
            n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 255);
            push_cmd(w, n);
          end else begin
            push_ticks($urandom_range(1, 5));
          end
        end
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Everything offered and taken, every result back, then a quiet wait to
    // catch anything extra the block might still send.
    wait (stim_q.size() == 0 && !s_tvalid && levels_q.size() == 0);
    repeat (10) @(posedge clk);

    $display("Run covered %0d ticks and %0d commands, %0d results checked in %0d cycles.",
             n_ticks, n_cmds, results_ok, cycles);
    $display("Patterns started: %0d, played to the end: %0d; long output hold-offs: %0d.",
             n_starts, n_finished, holds_done);
    if (errors == 0 && levels_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* beeper_pattern_generator.f */
hdl/bpg_pkg.sv
hdl/bpg_div.sv
hdl/beeper_pattern_generator.sv
hdl/bpg_checker.sv
verif/beeper_pattern_generator_test.sv
